[src/assert_macros.svh]
// Assertion macros shared by the RTL of the charge mode controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/ntcc_pkg.sv]
// Package of the NTC charge mode controller: types, codes, NTC table.
// No dependencies.
`timescale 1ns / 1ps
package ntcc_pkg;
    localparam int DIV_N_W = 26;
    localparam int DIV_D_W = 18;
    localparam int CNT_W = 5;
    localparam int NTC_POINTS = 17;
    localparam int SEG_W = 5;
    localparam logic [13:0] REF_OHMS = 14'd10000;
    localparam logic [12:0] ADC_FULL_SCALE = 13'd4096;
    localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] CFG_COLD_LIMIT = 3'd0;
    localparam logic [2:0] CFG_START_HOT = 3'd1;
    localparam logic [2:0] CFG_RUN_HOT = 3'd2;
    localparam logic [2:0] CFG_TRICKLE_TH = 3'd3;
    localparam logic [2:0] CFG_STANDARD_TH = 3'd4;
    localparam logic [2:0] CFG_TRICKLE_DUR = 3'd5;
    localparam logic [2:0] CFG_SHORT_DUR = 3'd6;
    localparam logic [2:0] CFG_LONG_DUR = 3'd7;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_STOPPED = 2'd1;
    localparam logic [1:0] MODE_STANDARD = 2'd2;
    localparam logic [1:0] MODE_TRICKLE = 2'd3;

    localparam logic CMD_DISCHARGE = 1'b1;

    typedef struct packed {
        logic              command;
        logic signed [7:0] temperature;
        logic [9:0]        battery_centivolts;
        logic              supply_ok;
        logic              health_test_busy;
        logic [47:0]       now_ticks;
    } t_item;

    typedef struct packed {
        logic signed [7:0] temperature;
        logic              charge_enable;
        logic              trickle_enable;
        logic [1:0]        charge_mode;
        logic              standard_timed_out;
        logic              trickle_timed_out;
    } t_result;

    function automatic logic [18:0] ntc_ohm(input logic [SEG_W-1:0] idx);
        logic [18:0] v;
        case (idx)
            5'd0: v = 19'd329500;
            5'd1: v = 19'd188500;
            5'd2: v = 19'd111300;
            5'd3: v = 19'd67770;
            5'd4: v = 19'd42470;
            5'd5: v = 19'd27280;
            5'd6: v = 19'd17960;
            5'd7: v = 19'd12090;
            5'd8: v = 19'd8313;
            5'd9: v = 19'd5827;
            5'd10: v = 19'd4160;
            5'd11: v = 19'd3020;
            5'd12: v = 19'd2228;
            5'd13: v = 19'd1668;
            5'd14: v = 19'd1266;
            5'd15: v = 19'd973;
            5'd16: v = 19'd757;
            default: v = 19'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [7:0] ntc_deg(input logic [SEG_W-1:0] idx);
        return 8'(signed'(9'(idx) * 9'sd10) - 9'sd50);
    endfunction

    // first segment end below r; 0 when r is at or below the table end
    function automatic logic [SEG_W-1:0] seg_find(input logic [DIV_N_W-1:0] r);
        logic [SEG_W-1:0] j;
        j = '0;
        for (int k = NTC_POINTS - 1; k >= 1; k--) begin
            if (r > DIV_N_W'(ntc_ohm(SEG_W'(k)))) begin
                j = SEG_W'(k);
            end
        end
        return j;
    endfunction
endpackage

[src/ntcc_in_if.sv]
// Input channel of the charge mode controller: valid/ready plus item fields.
// No dependencies.
`timescale 1ns / 1ps
interface ntcc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [11:0] thermistor_code;
    logic [9:0]  battery_centivolts;
    logic        supply_ok;
    logic        health_test_busy;
    logic [47:0] now_ticks;
    modport source (output valid, command, thermistor_code, battery_centivolts,
                    supply_ok, health_test_busy, now_ticks, input ready);
    modport sink (input valid, command, thermistor_code, battery_centivolts,
                  supply_ok, health_test_busy, now_ticks, output ready);
endinterface

[src/ntcc_out_if.sv]
// Result channel of the charge mode controller: valid/ready plus result fields.
// No dependencies.
`timescale 1ns / 1ps
interface ntcc_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] temperature;
    logic              charge_enable;
    logic              trickle_enable;
    logic [1:0]        charge_mode;
    logic              standard_timed_out;
    logic              trickle_timed_out;
    modport source (output valid, temperature, charge_enable, trickle_enable, charge_mode,
                    standard_timed_out, trickle_timed_out, input ready);
    modport sink (input valid, temperature, charge_enable, trickle_enable, charge_mode,
                  standard_timed_out, trickle_timed_out, output ready);
endinterface

[src/ntcc_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on ntcc_pkg.
`timescale 1ns / 1ps
module ntcc_div
    import ntcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_busy,
    output logic [DIV_N_W-1:0] o_quotient
);
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic [DIV_D_W:0]   trial;
    logic               q_bit;

    assign trial = {r_rem, r_quo[DIV_N_W-1]};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_N_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N_W-2:0], q_bit};
            r_rem <= q_bit ? DIV_D_W'(trial - {1'b0, r_div}) : trial[DIV_D_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

[src/ntcc_front.sv]
// Front end: accepts beats and converts the thermistor code to degrees.
// Depends on ntcc_pkg, ntcc_in_if and ntcc_div.
`timescale 1ns / 1ps
module ntcc_front
    import ntcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ntcc_in_if.sink    i_item,
    input  logic       i_full,
    output logic       o_push,
    output t_item      o_item
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_SEG   = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0]         r_state, n_state;
    t_item              r_item;
    logic [11:0]        r_code;
    logic [DIV_N_W-1:0] r_prod;
    logic [SEG_W-1:0]   r_seg;
    logic signed [7:0]  r_temp;

    logic               div_start;
    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic               div_busy;
    logic [DIV_N_W-1:0] div_q;
    logic [SEG_W-1:0]   seg;
    logic [18:0]        span;
    logic               accept;

    ntcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign accept = i_item.valid && i_item.ready;
    assign seg    = seg_find(div_q);
    assign span   = ntc_ohm(seg - 1'b1) - div_q[18:0];

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_n     = r_prod;
        div_d     = DIV_D_W'(ADC_FULL_SCALE - {1'b0, r_code});
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_START;
            end
            S_START: begin
                div_start = 1'b1;
                n_state   = S_DIV1;
            end
            S_DIV1: begin
                if (!div_busy) n_state = S_SEG;
            end
            S_SEG: begin
                if (seg == '0 || (seg == SEG_W'(1) && div_q > DIV_N_W'(ntc_ohm('0)))) begin
                    n_state = S_PUSH;
                end else begin
                    div_start = 1'b1;
                    div_n     = DIV_N_W'(span) * DIV_N_W'(4'd10);
                    div_d     = DIV_D_W'(ntc_ohm(seg - 1'b1) - ntc_ohm(seg));
                    n_state   = S_DIV2;
                end
            end
            S_DIV2: begin
                if (!div_busy) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!i_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code                    <= i_item.thermistor_code;
            r_prod                    <= DIV_N_W'(i_item.thermistor_code) * DIV_N_W'(REF_OHMS);
            r_item.command            <= i_item.command;
            r_item.battery_centivolts <= i_item.battery_centivolts;
            r_item.supply_ok          <= i_item.supply_ok;
            r_item.health_test_busy   <= i_item.health_test_busy;
            r_item.now_ticks          <= i_item.now_ticks;
            r_item.temperature        <= '0;
        end
        if (r_state == S_SEG) begin
            r_seg <= seg;
            if (seg == '0) r_temp <= '0;
            else r_temp <= -8'sd50;
        end
        if (r_state == S_DIV2 && !div_busy) begin
            r_temp <= ntc_deg(r_seg - 1'b1) + signed'({4'b0, div_q[3:0]});
        end
    end

    assign i_item.ready = (r_state == S_IDLE);
    assign o_push       = (r_state == S_PUSH) && !i_full;

    always_comb begin
        o_item             = r_item;
        o_item.temperature = r_temp;
    end
endmodule

[src/ntcc_fifo.sv]
// Two-entry queue between the front end and the control back end.
// Depends on ntcc_pkg.
`timescale 1ns / 1ps
module ntcc_fifo
    import ntcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);
    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop) r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];
endmodule

[src/ntcc_back.sv]
// Back end: charge control state, configuration registers, result register.
// Depends on ntcc_pkg and ntcc_out_if.
`timescale 1ns / 1ps
module ntcc_back
    import ntcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_empty,
    input  t_item       i_item,
    output logic        o_pop,
    ntcc_out_if.source  o_result
);
    logic signed [7:0] r_cold, r_start_hot, r_run_hot;
    logic [9:0]        r_trickle_th, r_standard_th;
    logic [31:0]       r_trickle_dur, r_short_dur, r_long_dur;

    logic        r_stopped, r_standard, r_trickle, r_std_to, r_trk_to;
    logic        r_started, r_pending, r_dropped, r_main, r_tline;
    logic [9:0]  r_latched;
    logic [47:0] r_std_dl, r_trk_dl;
    logic        n_stopped, n_standard, n_trickle, n_std_to, n_trk_to;
    logic        n_started, n_pending, n_dropped, n_main, n_tline;
    logic [9:0]  n_latched;
    logic [47:0] n_std_dl, n_trk_dl;

    t_result     r_out;
    logic        r_out_valid;
    t_result     res;
    logic [9:0]  volt;
    logic [31:0] dur;
    logic [48:0] sum;
    logic [47:0] deadline;
    logic signed [7:0] t;
    logic [47:0] now;

    assign o_pop = !i_empty && (!r_out_valid || o_result.ready);
    assign t     = i_item.temperature;
    assign now   = i_item.now_ticks;

    // voltage seen by the mode choice, after a possible new sample
    always_comb begin
        volt = (r_pending || (r_dropped && i_item.supply_ok)) ? i_item.battery_centivolts
                                                              : r_latched;
        if (volt > r_trickle_th) dur = r_trickle_dur;
        else if (volt > r_standard_th) dur = r_short_dur;
        else dur = r_long_dur;
        sum      = {1'b0, now} + 49'(dur);
        deadline = sum[48] ? TICK_MAX : sum[47:0];
    end

    always_comb begin
        n_stopped  = r_stopped;
        n_standard = r_standard;
        n_trickle  = r_trickle;
        n_std_to   = r_std_to;
        n_trk_to   = r_trk_to;
        n_started  = r_started;
        n_pending  = r_pending;
        n_dropped  = r_dropped;
        n_main     = r_main;
        n_tline    = r_tline;
        n_latched  = r_latched;
        n_std_dl   = r_std_dl;
        n_trk_dl   = r_trk_dl;
        if (i_item.command == CMD_DISCHARGE) begin
            n_stopped  = 1'b0;
            n_standard = 1'b0;
            n_trickle  = 1'b0;
        end else if (!i_item.health_test_busy) begin
            if (i_item.supply_ok) begin
                if (r_dropped) begin
                    n_pending = 1'b1;
                    n_dropped = 1'b0;
                end
            end else begin
                n_dropped = 1'b1;
            end
            if ((t < r_cold || t > r_start_hot) && !r_started) begin
                if (!r_stopped) begin
                    n_main = 1'b0; n_tline = 1'b0;
                    n_stopped = 1'b1; n_standard = 1'b0; n_trickle = 1'b0;
                end
            end else begin
                n_started = 1'b1;
                if (n_pending) begin
                    n_pending = 1'b0;
                    n_latched = i_item.battery_centivolts;
                end
                if (t < r_cold || t > r_run_hot) begin
                    if (!r_stopped) begin
                        n_main = 1'b0; n_tline = 1'b0;
                        n_stopped = 1'b1; n_standard = 1'b0; n_trickle = 1'b0;
                    end
                end else if (n_latched > r_trickle_th) begin
                    if (!r_trickle && !r_trk_to) begin
                        n_tline = 1'b1; n_main = 1'b0;
                        n_stopped = 1'b0; n_standard = 1'b0; n_trickle = 1'b1;
                        n_trk_dl = deadline;
                    end else if (now > r_trk_dl && !r_stopped) begin
                        n_main = 1'b0; n_tline = 1'b0;
                        n_stopped = 1'b1; n_standard = 1'b0; n_trickle = 1'b0;
                        n_trk_to = 1'b1;
                    end
                end else begin
                    if (!r_standard && !r_std_to) begin
                        n_tline = 1'b1; n_main = 1'b1;
                        n_stopped = 1'b0; n_standard = 1'b1; n_trickle = 1'b0;
                        n_std_dl = deadline;
                    end else if (now > r_std_dl && !r_stopped) begin
                        n_main = 1'b0; n_tline = 1'b0;
                        n_stopped = 1'b1; n_standard = 1'b0; n_trickle = 1'b0;
                        n_std_to = 1'b1;
                    end
                end
            end
        end
        res.temperature        = t;
        res.charge_enable      = n_main;
        res.trickle_enable     = n_tline;
        res.standard_timed_out = n_std_to;
        res.trickle_timed_out  = n_trk_to;
        if (n_trickle) res.charge_mode = MODE_TRICKLE;
        else if (n_standard) res.charge_mode = MODE_STANDARD;
        else if (n_stopped) res.charge_mode = MODE_STOPPED;
        else res.charge_mode = MODE_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cold        <= -8'sd20;
            r_start_hot   <= 8'sd60;
            r_run_hot     <= 8'sd70;
            r_trickle_th  <= 10'd402;
            r_standard_th <= 10'd390;
            r_trickle_dur <= 32'd1440000;
            r_short_dur   <= 32'd2160000;
            r_long_dur    <= 32'd4320000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLD_LIMIT:  r_cold        <= signed'(i_cfg_data[7:0]);
                CFG_START_HOT:   r_start_hot   <= signed'(i_cfg_data[7:0]);
                CFG_RUN_HOT:     r_run_hot     <= signed'(i_cfg_data[7:0]);
                CFG_TRICKLE_TH:  r_trickle_th  <= i_cfg_data[9:0];
                CFG_STANDARD_TH: r_standard_th <= i_cfg_data[9:0];
                CFG_TRICKLE_DUR: r_trickle_dur <= i_cfg_data;
                CFG_SHORT_DUR:   r_short_dur   <= i_cfg_data;
                CFG_LONG_DUR:    r_long_dur    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped <= 1'b0; r_standard <= 1'b0; r_trickle <= 1'b0;
            r_std_to  <= 1'b0; r_trk_to   <= 1'b0; r_started <= 1'b0;
            r_pending <= 1'b1; r_dropped  <= 1'b0;
            r_main    <= 1'b0; r_tline    <= 1'b0;
            r_latched <= '0;   r_std_dl   <= '0;   r_trk_dl  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_stopped <= n_stopped; r_standard <= n_standard; r_trickle <= n_trickle;
                r_std_to  <= n_std_to;  r_trk_to   <= n_trk_to;   r_started <= n_started;
                r_pending <= n_pending; r_dropped  <= n_dropped;
                r_main    <= n_main;    r_tline    <= n_tline;
                r_latched <= n_latched; r_std_dl   <= n_std_dl;   r_trk_dl  <= n_trk_dl;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_out <= res;
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.temperature        = r_out.temperature;
    assign o_result.charge_enable      = r_out.charge_enable;
    assign o_result.trickle_enable     = r_out.trickle_enable;
    assign o_result.charge_mode        = r_out.charge_mode;
    assign o_result.standard_timed_out = r_out.standard_timed_out;
    assign o_result.trickle_timed_out  = r_out.trickle_timed_out;
endmodule

[src/ntc_charge_mode_controller_unit.sv]
// NTC charge mode controller, top level.
// Uses the input item channel i_item and the result channel o_result (valid/ready).
// Depends on ntcc_pkg, both channel interfaces, ntcc_front, ntcc_fifo, ntcc_back.
// Each beat on i_item (charge or discharge tick) yields exactly one result beat
// on o_result, in order. The front end turns the thermistor code into degrees
// with one shared 26-step serial divider used twice (resistance, then the
// interpolation inside a table segment); codes at or below the table end or
// above its start skip the second pass. The front end takes a new beat only
// after it has pushed the last one. A two-beat queue and a result register
// let the front end take the next beat while a result waits.
// Configuration writes on i_cfg_we/i_cfg_idx/i_cfg_data take effect at the
// next edge and must only happen while the block is idle.
// Synchronous active-low reset loads the register defaults, clears the mode
// and timeout flags, marks a voltage sample pending and drops both enables.
// When o_result is stalled, results back up into the queue and then i_item
// ready stays low until space frees up.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ntc_charge_mode_controller_unit
    import ntcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntcc_in_if.sink     i_item,
    ntcc_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    logic  push, pop, full, empty;
    t_item front_item, queue_item;

    ntcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_item  (front_item)
    );

    ntcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    ntcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (empty),
        .i_item     (queue_item),
        .o_pop      (pop),
        .o_result   (o_result)
    );

    `ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, push, !full)
    `ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, pop, !empty)
    `ASSERT_IMPLY(a_trickle_lines, i_clk, i_rst_n,
        o_result.valid && o_result.charge_mode == MODE_TRICKLE,
        o_result.trickle_enable && !o_result.charge_enable)
    `ASSERT_IMPLY(a_standard_lines, i_clk, i_rst_n,
        o_result.valid && o_result.charge_mode == MODE_STANDARD,
        o_result.trickle_enable && o_result.charge_enable)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n,
        i_item.valid && i_item.ready, !i_item.ready)
endmodule
